[hw/rtl/afo_pkg.sv]
// Types and constants shared by the accumulator/flag operation unit.
// No dependencies; compiled first.
`default_nettype none

package afo_pkg;

  typedef enum logic [3:0] {
    OP_DAA  = 4'd0,
    OP_CPL  = 4'd1,
    OP_CCF  = 4'd2,
    OP_SCF  = 4'd3,
    OP_RLCA = 4'd4,
    OP_RRCA = 4'd5,
    OP_RLA  = 4'd6,
    OP_RRA  = 4'd7,
    OP_RLD  = 4'd8,
    OP_RRD  = 4'd9
  } op_t;

  // Flag bit positions: S Z Y H X P N C
  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_N = 1;
  localparam int unsigned FL_P = 2;
  localparam int unsigned FL_X = 3;
  localparam int unsigned FL_H = 4;
  localparam int unsigned FL_Y = 5;
  localparam int unsigned FL_Z = 6;
  localparam int unsigned FL_S = 7;

  localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
  localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

  typedef struct packed {
    logic [3:0] operation;
    logic [7:0] acc_in;
    logic [7:0] flags_in;
    logic [7:0] mem_in;
    logic       prev_q;
  } afo_req_t;

  typedef struct packed {
    logic [7:0] acc_out;
    logic [7:0] flags_out;
    logic [7:0] mem_out;
    logic       mem_write;
  } afo_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/afo_if.sv]
// Valid/ready channel interfaces for the operation request and the result.
// Standalone; no package needed.
`default_nettype none

interface afo_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] operation;
  logic [7:0] acc_in;
  logic [7:0] flags_in;
  logic [7:0] mem_in;
  logic       prev_q;

  modport source (output valid, operation, acc_in, flags_in, mem_in, prev_q,
                  input ready);
  modport sink   (input valid, operation, acc_in, flags_in, mem_in, prev_q,
                  output ready);
endinterface

interface afo_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] acc_out;
  logic [7:0] flags_out;
  logic [7:0] mem_out;
  logic       mem_write;

  modport source (output valid, acc_out, flags_out, mem_out, mem_write,
                  input ready);
  modport sink   (input valid, acc_out, flags_out, mem_out, mem_write,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/accumulator_flag_ops_unit.sv]
// Top level of the accumulator/flag operation unit: request register,
// datapath (afo_core), result register. Depends on afo_pkg and afo_if.
`default_nettype none

// Executes DAA, CPL, CCF, SCF, RLCA, RRCA, RLA, RRA, RLD and RRD. One
// transaction is accepted every cycle while out_ch keeps up; each produces
// exactly one result, carried by the request register, then the result
// register. The datapath between the two registers is a single pass of short
// logic. in_ch.ready drops only when both registers hold entries that out_ch
// has not taken. Codes 10 to 15 pass A and F through and do not write memory;
// mem_out is zero unless mem_write is set.

module accumulator_flag_ops_unit (
  input  wire        clk,
  input  wire        rst_n,
  afo_in_if.sink     in_ch,
  afo_out_if.source  out_ch
);
  import afo_pkg::*;

  logic     req_vld_r;
  logic     req_vld_nxt;
  afo_req_t req_r;
  afo_rsp_t rsp_nxt;
  logic     rsp_vld_r;
  logic     rsp_vld_nxt;
  afo_rsp_t rsp_r;
  logic     rsp_free;
  logic     req_free;
  logic     in_fire;
  logic     req_move;

  assign rsp_free = !rsp_vld_r || out_ch.ready;
  assign req_free = !req_vld_r || rsp_free;
  assign in_fire  = in_ch.valid && req_free;
  assign req_move = req_vld_r && rsp_free;

  assign in_ch.ready = req_free;

  assign req_vld_nxt = in_fire || (req_vld_r && !rsp_free);
  assign rsp_vld_nxt = req_move || (rsp_vld_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      rsp_vld_r <= 1'b0;
    end else begin
      req_vld_r <= req_vld_nxt;
      rsp_vld_r <= rsp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r.operation <= in_ch.operation;
      req_r.acc_in    <= in_ch.acc_in;
      req_r.flags_in  <= in_ch.flags_in;
      req_r.mem_in    <= in_ch.mem_in;
      req_r.prev_q    <= in_ch.prev_q;
    end
    if (req_move) begin
      rsp_r <= rsp_nxt;
    end
  end

  afo_core u_core (
    .req (req_r),
    .rsp (rsp_nxt)
  );

  assign out_ch.valid     = rsp_vld_r;
  assign out_ch.acc_out   = rsp_r.acc_out;
  assign out_ch.flags_out = rsp_r.flags_out;
  assign out_ch.mem_out   = rsp_r.mem_out;
  assign out_ch.mem_write = rsp_r.mem_write;

  // accepted transaction lands in the request register
  a_req_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> req_vld_r)
    else $error("accepted transaction not held in request register");

  // request held while the result stage is blocked
  a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
    req_vld_r && !rsp_free |=> req_vld_r && $stable(req_r))
    else $error("request lost during result stall");

  // result register takes the datapath output on a move
  a_rsp_load: assert property (@(posedge clk) disable iff (!rst_n)
    req_move |=> rsp_vld_r && (rsp_r == $past(rsp_nxt)))
    else $error("result register does not match datapath");

  // no memory write means the write-back byte is zero
  a_mem_zero: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_vld_r && !rsp_r.mem_write |-> rsp_r.mem_out == 8'h00)
    else $error("mem_out nonzero without mem_write");

endmodule

`default_nettype wire

[hw/rtl/afo_core.sv]
// Combinational datapath: one registered request in, one result out.
// Depends on afo_pkg.
`default_nettype none

module afo_core (
  input  afo_pkg::afo_req_t req,
  output afo_pkg::afo_rsp_t rsp
);
  import afo_pkg::*;

  logic [7:0] a;
  logic [7:0] f;
  logic [7:0] m;
  logic       sub;
  logic       hi_fix;
  logic       lo_fix;
  logic [7:0] daa_t;
  logic [7:0] daa_a;
  logic [7:0] na;
  logic [7:0] nf;
  logic [7:0] mo;
  logic       mw;
  logic       rot_c;

  assign a   = req.acc_in;
  assign f   = req.flags_in;
  assign m   = req.mem_in;
  assign sub = f[FL_N];

  // DAA: high correction decided on the original value, low on the partial one
  assign hi_fix = f[FL_C] || (a > DAA_HI_LIMIT);
  assign daa_t  = !hi_fix ? a : (sub ? a - DAA_HI_ADJ : a + DAA_HI_ADJ);
  assign lo_fix = f[FL_H] || (daa_t[3:0] > DAA_LO_LIMIT);
  assign daa_a  = !lo_fix ? daa_t : (sub ? daa_t - DAA_LO_ADJ : daa_t + DAA_LO_ADJ);

  always_comb begin
    na    = a;
    nf    = f;
    mo    = 8'h00;
    mw    = 1'b0;
    rot_c = 1'b0;
    case (op_t'(req.operation))
      OP_DAA: begin
        na        = daa_a;
        nf[FL_C]  = f[FL_C] | hi_fix;
        nf[FL_S]  = na[7];
        nf[FL_Z]  = (na == 8'h00);
        nf[FL_Y]  = na[5];
        nf[FL_X]  = na[3];
        nf[FL_P]  = ~^na;
        nf[FL_H]  = a[4] ^ na[4];
      end
      OP_CPL: begin
        na       = ~a;
        nf[FL_Y] = na[5];
        nf[FL_X] = na[3];
        nf[FL_N] = 1'b1;
        nf[FL_H] = 1'b1;
      end
      OP_CCF, OP_SCF: begin
        // with Q set the old X/Y are dropped before ORing in A bits
        nf[FL_Y] = (f[FL_Y] & ~req.prev_q) | a[5];
        nf[FL_X] = (f[FL_X] & ~req.prev_q) | a[3];
        nf[FL_N] = 1'b0;
        if (op_t'(req.operation) == OP_CCF) begin
          nf[FL_H] = f[FL_C];
          nf[FL_C] = ~f[FL_C];
        end else begin
          nf[FL_H] = 1'b0;
          nf[FL_C] = 1'b1;
        end
      end
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        case (op_t'(req.operation))
          OP_RLCA: begin
            rot_c = a[7];
            na    = {a[6:0], a[7]};
          end
          OP_RRCA: begin
            rot_c = a[0];
            na    = {a[0], a[7:1]};
          end
          OP_RLA: begin
            rot_c = a[7];
            na    = {a[6:0], f[FL_C]};
          end
          default: begin
            rot_c = a[0];
            na    = {f[FL_C], a[7:1]};
          end
        endcase
        nf[FL_Y] = na[5];
        nf[FL_X] = na[3];
        nf[FL_N] = 1'b0;
        nf[FL_H] = 1'b0;
        nf[FL_C] = rot_c;
      end
      OP_RLD, OP_RRD: begin
        if (op_t'(req.operation) == OP_RLD) begin
          mo = {m[3:0], a[3:0]};
          na = {a[7:4], m[7:4]};
        end else begin
          mo = {a[3:0], m[7:4]};
          na = {a[7:4], m[3:0]};
        end
        mw       = 1'b1;
        nf[FL_S] = na[7];
        nf[FL_Z] = (na == 8'h00);
        nf[FL_Y] = na[5];
        nf[FL_X] = na[3];
        nf[FL_P] = ~^na;
        nf[FL_N] = 1'b0;
        nf[FL_H] = 1'b0;
      end
      default: begin
        // unused codes: pass through, no write
        na = a;
        nf = f;
      end
    endcase
  end

  assign rsp.acc_out   = na;
  assign rsp.flags_out = nf;
  assign rsp.mem_out   = mo;
  assign rsp.mem_write = mw;

endmodule

`default_nettype wire

[sim/afo_result_checker.sv]
// Result checker for accumulator_flag_ops_unit: watches both channels, predicts
// each result from the accepted request and compares it field by field.
// Depends on afo_pkg and the afo_in_if / afo_out_if interfaces.
`timescale 1ns / 100ps

module afo_result_checker (
  input  wire   clk,
  input  wire   rst_n,
  afo_in_if     in_ch,
  afo_out_if    out_ch,
  output int    fail_count,
  output int    pending
);
  import afo_pkg::*;

  afo_rsp_t pending_results[$];

  // S, Z, Y, X and P all follow the new accumulator
  function automatic logic [7:0] with_szxyp(logic [7:0] f, logic [7:0] acc);
    logic [7:0] nf;
    nf = f;
    nf[FL_S] = acc[7];
    nf[FL_Z] = (acc == 8'h00);
    nf[FL_Y] = acc[FL_Y];
    nf[FL_X] = acc[FL_X];
    nf[FL_P] = ~^acc;
    return nf;
  endfunction

  function automatic logic [7:0] with_xy(logic [7:0] f, logic [7:0] acc);
    logic [7:0] nf;
    nf = f;
    nf[FL_Y] = acc[FL_Y];
    nf[FL_X] = acc[FL_X];
    return nf;
  endfunction

  function automatic afo_rsp_t alu_result(afo_req_t r);
    afo_rsp_t   res;
    logic [7:0] a;
    logic [7:0] f;
    logic [7:0] na;
    logic [7:0] nf;
    logic       cy;
    a  = r.acc_in;
    f  = r.flags_in;
    na = a;
    nf = f;
    cy = 1'b0;
    res.mem_out   = 8'h00;
    res.mem_write = 1'b0;
    case (r.operation)
      OP_DAA: begin
        if (f[FL_C] || a > DAA_HI_LIMIT) begin
          na = f[FL_N] ? na - DAA_HI_ADJ : na + DAA_HI_ADJ;
          nf[FL_C] = 1'b1;
        end
        // low nibble is tested after the high correction
        if (f[FL_H] || na[3:0] > DAA_LO_LIMIT)
          na = f[FL_N] ? na - DAA_LO_ADJ : na + DAA_LO_ADJ;
        nf = with_szxyp(nf, na);
        nf[FL_H] = a[FL_H] ^ na[FL_H];
      end
      OP_CPL: begin
        na = ~a;
        nf = with_xy(f, na);
        nf[FL_N] = 1'b1;
        nf[FL_H] = 1'b1;
      end
      OP_CCF, OP_SCF: begin
        if (r.prev_q) begin
          nf[FL_X] = 1'b0;
          nf[FL_Y] = 1'b0;
        end
        nf[FL_X] = nf[FL_X] | a[FL_X];
        nf[FL_Y] = nf[FL_Y] | a[FL_Y];
        nf[FL_N] = 1'b0;
        nf[FL_H] = 1'b0;
        if (r.operation == OP_CCF) begin
          nf[FL_H] = f[FL_C];
          nf[FL_C] = ~f[FL_C];
        end else begin
          nf[FL_C] = 1'b1;
        end
      end
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        case (r.operation)
          OP_RLCA: begin
            cy = a[7];
            na = {a[6:0], a[7]};
          end
          OP_RRCA: begin
            cy = a[0];
            na = {a[0], a[7:1]};
          end
          OP_RLA: begin
            cy = a[7];
            na = {a[6:0], f[FL_C]};
          end
          default: begin
            cy = a[0];
            na = {f[FL_C], a[7:1]};
          end
        endcase
        nf = with_xy(f, na);
        nf[FL_N] = 1'b0;
        nf[FL_H] = 1'b0;
        nf[FL_C] = cy;
      end
      OP_RLD, OP_RRD: begin
        if (r.operation == OP_RLD) begin
          res.mem_out = {r.mem_in[3:0], a[3:0]};
          na = {a[7:4], r.mem_in[7:4]};
        end else begin
          res.mem_out = {a[3:0], r.mem_in[7:4]};
          na = {a[7:4], r.mem_in[3:0]};
        end
        res.mem_write = 1'b1;
        nf = with_szxyp(f, na);
        nf[FL_N] = 1'b0;
        nf[FL_H] = 1'b0;
      end
      default: ; // unused codes pass A and F through
    endcase
    res.acc_out   = na;
    res.flags_out = nf;
    return res;
  endfunction

  function automatic int field_diff(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    afo_req_t req;
    afo_rsp_t seen;
    afo_rsp_t want;
    int       errs;
    errs = 0;
    if (!rst_n) begin
      pending_results.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      // check the outgoing transaction first: a result never pairs with a
      // request accepted at the same edge
      if (out_ch.valid && out_ch.ready) begin
        seen = '{out_ch.acc_out, out_ch.flags_out, out_ch.mem_out, out_ch.mem_write};
        if (pending_results.size() == 0) begin
          $error("result transaction with no request outstanding");
          errs = 1;
        end else begin
          want = pending_results.pop_front();
          errs += field_diff("acc_out", want.acc_out, seen.acc_out);
          errs += field_diff("flags_out", want.flags_out, seen.flags_out);
          errs += field_diff("mem_out", want.mem_out, seen.mem_out);
          errs += field_diff("mem_write", {7'd0, want.mem_write}, {7'd0, seen.mem_write});
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        req = '{in_ch.operation, in_ch.acc_in, in_ch.flags_in, in_ch.mem_in, in_ch.prev_q};
        pending_results.push_back(alu_result(req));
      end
      fail_count <= fail_count + errs;
      pending    <= pending_results.size();
    end
  end

endmodule

[sim/accumulator_flag_ops_unit_tb.sv]
// Testbench top for accumulator_flag_ops_unit: clock, reset, request stimulus,
// result back-pressure and verdict. Checking lives in afo_result_checker.
// Depends on afo_pkg, afo_if and afo_result_checker.
`timescale 1ns / 100ps

module accumulator_flag_ops_unit_tb;
  import afo_pkg::*;

  localparam logic [3:0] OP_UNUSED_LO = 4'd10;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  localparam logic [7:0] FM_C = 8'b1 << FL_C;
  localparam logic [7:0] FM_N = 8'b1 << FL_N;
  localparam logic [7:0] FM_X = 8'b1 << FL_X;
  localparam logic [7:0] FM_H = 8'b1 << FL_H;
  localparam logic [7:0] FM_Y = 8'b1 << FL_Y;

  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT = 1000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   quiet_cycles;
  int   hold_reqs;
  int   holds_done;

  afo_in_if  in_ch ();
  afo_out_if out_ch ();

  accumulator_flag_ops_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  afo_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random back-pressure, plus a long hold on request
  initial begin
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_reqs) begin
        holds_done = holds_done + 1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("accumulator_flag_ops_unit_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic issue(input afo_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= r.operation;
    in_ch.acc_in    <= r.acc_in;
    in_ch.flags_in  <= r.flags_in;
    in_ch.mem_in    <= r.mem_in;
    in_ch.prev_q    <= r.prev_q;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic afo_req_t random_req();
    afo_req_t r;
    // mostly real operations, some unused codes
    if ($urandom_range(9) == 0)
      r.operation = 4'($urandom_range(15, 10));
    else
      r.operation = 4'($urandom_range(9));
    r.acc_in   = 8'($urandom_range(255));
    r.flags_in = 8'($urandom_range(255));
    r.mem_in   = 8'($urandom_range(255));
    r.prev_q   = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic run_random(input int n);
    repeat (n) issue(random_req());
  endtask

  initial begin
    tx_idle_pct = 30;
    rx_idle_pct = 57;
    hold_reqs   = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_DAA;
    in_ch.acc_in    <= 8'h00;
    in_ch.flags_in  <= 8'h00;
    in_ch.mem_in    <= 8'h00;
    in_ch.prev_q    <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: DAA corrections both ways, flag-driven and value-driven
    issue('{OP_DAA, 8'h00, 8'h00, 8'h00, 1'b0});
    issue('{OP_DAA, 8'h9a, 8'h00, 8'h00, 1'b1});
    issue('{OP_DAA, 8'h0f, FM_N, 8'h00, 1'b0});
    issue('{OP_DAA, 8'h99, FM_C | FM_H, 8'h00, 1'b0});
    issue('{OP_DAA, 8'hff, FM_N | FM_C | FM_H, 8'hff, 1'b1});
    issue('{OP_DAA, 8'h66, FM_N | FM_H, 8'h00, 1'b0});
    issue('{OP_CPL, 8'h00, 8'hff, 8'h00, 1'b0});
    issue('{OP_CPL, 8'hff, 8'h00, 8'hff, 1'b1});
    // CCF/SCF with Q set and clear
    issue('{OP_CCF, 8'h28, 8'hff, 8'h00, 1'b1});
    issue('{OP_CCF, 8'h00, 8'h00, 8'h00, 1'b0});
    issue('{OP_SCF, 8'hff, 8'h00, 8'h00, 1'b1});
    issue('{OP_SCF, 8'h00, FM_X | FM_Y, 8'h00, 1'b0});
    issue('{OP_SCF, 8'h00, FM_X | FM_Y, 8'h00, 1'b1});
    issue('{OP_RLCA, 8'h80, 8'h00, 8'h00, 1'b0});
    issue('{OP_RRCA, 8'h01, 8'hff, 8'h00, 1'b0});
    issue('{OP_RLA, 8'h80, FM_C, 8'h00, 1'b1});
    issue('{OP_RRA, 8'h01, FM_C, 8'h00, 1'b0});
    issue('{OP_RLD, 8'hf0, 8'h00, 8'hab, 1'b0});
    issue('{OP_RLD, 8'h00, 8'hff, 8'h00, 1'b1});
    issue('{OP_RRD, 8'h0f, 8'h00, 8'hff, 1'b0});
    issue('{OP_RRD, 8'hff, 8'hff, 8'h00, 1'b1});
    issue('{OP_UNUSED_LO, 8'hff, 8'hff, 8'hff, 1'b1});
    issue('{OP_UNUSED_HI, 8'h00, 8'h00, 8'h00, 1'b0});

    // long result-side hold while requests keep coming
    hold_reqs = hold_reqs + 1;
    run_random(280);

    tx_idle_pct = 57;
    rx_idle_pct = 30;
    run_random(260);

    // sender pause until the pipeline is empty
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(260);

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("accumulator_flag_ops_unit_tb: PASS");
    else
      $display("accumulator_flag_ops_unit_tb: FAIL");
    $finish;
  end

endmodule
